/* hw/rtl/serial_drive_command_decoder_defines.svh */
// ----------------------------------------------------------------------------
// Serial drive command decoder: assertion macros
// Wrappers for concurrent checks, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_DRIVE_COMMAND_DECODER_DEFINES_SVH
`define SERIAL_DRIVE_COMMAND_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SDCD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdcd assertion failed");

// Next-cycle implication
`define SDCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdcd assertion failed");

`else

`define SDCD_ASSERT_IMPL(label, ante, cons)
`define SDCD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/sdcd_pkg.sv */
// ----------------------------------------------------------------------------
// sdcd_pkg
// Types, character codes and arithmetic constants of the drive command decoder.
// ----------------------------------------------------------------------------
package sdcd_pkg;

  // Widths
  localparam int unsigned CmdW   = 9;
  localparam int unsigned ShaftW = 7;
  localparam int unsigned DutyW  = 13;
  localparam int unsigned OpW    = 16;
  localparam int unsigned ProdW  = 2 * OpW;
  localparam int unsigned TmpW   = 10;

  // Character codes
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_S     = 8'd115;
  localparam logic [7:0] CH_A     = 8'd97;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_MINUS = 8'd45;

  // Reset value of the shaft length register
  localparam logic [ShaftW-1:0] ShaftReset = 7'd44;

  // Divide by 100 as (x * Recip100) >> Shift100, exact for x below 2^15
  localparam logic [OpW-1:0] Recip100 = 16'd20972;
  localparam int unsigned    Shift100 = 21;
  // Divide by 10 as (x * Recip10) >> Shift10, exact for x below 2^16
  localparam logic [OpW-1:0] Recip10  = 16'd52429;
  localparam int unsigned    Shift10  = 19;
  // Duty = (DutyGain * mag - DutyOffset) / 10
  localparam logic [OpW-1:0] DutyGain   = 16'd125;
  localparam logic [OpW-1:0] DutyOffset = 16'd7;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RECV,
    PH_LIN_SIGN,
    PH_LIN_MAG,
    PH_ANG_SIGN,
    PH_ANG_MAG
  } phase_e;

  typedef enum logic [3:0] {
    MX_IDLE,
    MX_ANG,
    MX_TMP,
    MX_MIX,
    MX_L125,
    MX_L10,
    MX_R125,
    MX_R10,
    MX_DONE
  } mix_state_e;

  typedef enum logic [1:0] {
    ACK_NONE = 2'd0,
    ACK_RECV = 2'd1,
    ACK_DONE = 2'd2
  } ack_e;

  // Latched speed commands, two's complement
  typedef struct packed {
    logic [CmdW-1:0] lin;
    logic [CmdW-1:0] ang;
  } cmd_t;

endpackage

/* hw/rtl/sdcd_mul.sv */
// ----------------------------------------------------------------------------
// sdcd_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module sdcd_mul (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [sdcd_pkg::OpW-1:0]     a_i,
  input  logic [sdcd_pkg::OpW-1:0]     b_i,
  output logic [sdcd_pkg::ProdW-1:0]   prod_o
);

  logic [sdcd_pkg::ProdW-1:0] prod_d;
  logic [sdcd_pkg::ProdW-1:0] prod_q;

  // Form the full-width product
  assign prod_d = {{sdcd_pkg::OpW{1'b0}}, a_i} * {{sdcd_pkg::OpW{1'b0}}, b_i};

  // Capture the product while en_i is high
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

/* hw/rtl/sdcd_parser.sv */
// ----------------------------------------------------------------------------
// sdcd_parser
// Command parser: tracks the receive phase and latches speed commands.
// ----------------------------------------------------------------------------
module sdcd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           rx_byte_i,
  output sdcd_pkg::cmd_t       cmd_o,
  output sdcd_pkg::ack_e       ack_o,
  output logic                 mix_start_o
);

  sdcd_pkg::phase_e                 phase_q, phase_d;
  logic                             neg_q, neg_d;
  logic [sdcd_pkg::CmdW-1:0]        lin_q, lin_d;
  logic [sdcd_pkg::CmdW-1:0]        ang_q, ang_d;
  logic [sdcd_pkg::CmdW-1:0]        value;

  // Minus sign stores the one's complement, which is -mag-1
  assign value = neg_q ? ~{1'b0, rx_byte_i} : {1'b0, rx_byte_i};

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      case (phase_q)
        sdcd_pkg::PH_IDLE: begin
          if (rx_byte_i == sdcd_pkg::CH_COLON) phase_d = sdcd_pkg::PH_RECV;
        end
        sdcd_pkg::PH_RECV: begin
          if (rx_byte_i == sdcd_pkg::CH_S) begin
            phase_d = sdcd_pkg::PH_LIN_SIGN;
          end else if (rx_byte_i == sdcd_pkg::CH_A) begin
            phase_d = sdcd_pkg::PH_ANG_SIGN;
          end else if (rx_byte_i == sdcd_pkg::CH_ESC) begin
            phase_d = sdcd_pkg::PH_IDLE;
          end
        end
        sdcd_pkg::PH_LIN_SIGN: phase_d = sdcd_pkg::PH_LIN_MAG;
        sdcd_pkg::PH_LIN_MAG:  phase_d = sdcd_pkg::PH_RECV;
        sdcd_pkg::PH_ANG_SIGN: phase_d = sdcd_pkg::PH_ANG_MAG;
        sdcd_pkg::PH_ANG_MAG:  phase_d = sdcd_pkg::PH_RECV;
        default:               phase_d = sdcd_pkg::PH_IDLE;
      endcase
    end
  end

  // Outputs and command updates
  always_comb begin
    ack_o       = sdcd_pkg::ACK_NONE;
    mix_start_o = 1'b0;
    neg_d       = neg_q;
    lin_d       = lin_q;
    ang_d       = ang_q;
    if (accept_i) begin
      case (phase_q)
        sdcd_pkg::PH_IDLE: begin
          if (rx_byte_i == sdcd_pkg::CH_COLON) ack_o = sdcd_pkg::ACK_RECV;
        end
        sdcd_pkg::PH_RECV: begin
          if ((rx_byte_i != sdcd_pkg::CH_S) && (rx_byte_i != sdcd_pkg::CH_A) &&
              (rx_byte_i == sdcd_pkg::CH_ESC)) begin
            mix_start_o = 1'b1;
          end
        end
        sdcd_pkg::PH_LIN_SIGN: neg_d = (rx_byte_i == sdcd_pkg::CH_MINUS);
        sdcd_pkg::PH_LIN_MAG:  lin_d = value;
        sdcd_pkg::PH_ANG_SIGN: neg_d = (rx_byte_i == sdcd_pkg::CH_MINUS);
        sdcd_pkg::PH_ANG_MAG:  ang_d = value;
        default: begin
          ack_o = sdcd_pkg::ACK_NONE;
        end
      endcase
    end
  end

  // Hold phase and commands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdcd_pkg::PH_IDLE;
      neg_q   <= 1'b0;
      lin_q   <= '0;
      ang_q   <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      lin_q   <= lin_d;
      ang_q   <= ang_d;
    end
  end

  assign cmd_o.lin = lin_q;
  assign cmd_o.ang = ang_q;

endmodule

/* hw/rtl/sdcd_mix_seq.sv */
// ----------------------------------------------------------------------------
// sdcd_mix_seq
// Mixing sequencer: runs the differential-drive math through one multiplier
// and holds the wheel duty and direction registers.
// ----------------------------------------------------------------------------
module sdcd_mix_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  sdcd_pkg::cmd_t                    cmd_i,
  input  logic [sdcd_pkg::ShaftW-1:0]       shaft_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [sdcd_pkg::DutyW-1:0]        left_duty_o,
  output logic [sdcd_pkg::DutyW-1:0]        right_duty_o,
  output logic                              left_fwd_o,
  output logic                              right_fwd_o
);

  localparam int unsigned MagW = sdcd_pkg::CmdW;
  localparam int unsigned SumW = sdcd_pkg::CmdW + 2;

  sdcd_pkg::mix_state_e              state_q, state_d;

  logic                              mul_en;
  logic [sdcd_pkg::OpW-1:0]          op_a, op_b;
  logic [sdcd_pkg::ProdW-1:0]        prod;

  logic [sdcd_pkg::CmdW-1:0]         ang_abs;
  logic [sdcd_pkg::TmpW-1:0]         tmp_mag;
  logic [SumW-1:0]                   tmp_ext, tmp_s, lin2, sum_l, sum_r, abs_l, abs_r;
  logic [MagW-1:0]                   mag_l, mag_r;
  logic                              fwd_l, fwd_r;
  logic [sdcd_pkg::OpW-1:0]          duty_num;
  logic [sdcd_pkg::DutyW-1:0]        duty_quo;

  logic [MagW-1:0]                   lmag_q, rmag_q;
  logic                              lfwd_q, rfwd_q;
  logic [sdcd_pkg::DutyW-1:0]        lduty_q, rduty_q;
  logic                              load_mix, load_left, load_right;

  sdcd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  // Absolute angular command; -256 maps to 256
  assign ang_abs = cmd_i.ang[sdcd_pkg::CmdW-1] ? (~cmd_i.ang + 1'b1) : cmd_i.ang;

  // Angular term: quotient by 100, sign restored
  assign tmp_mag = prod[sdcd_pkg::Shift100 +: sdcd_pkg::TmpW];
  assign tmp_ext = {1'b0, tmp_mag};
  assign tmp_s   = cmd_i.ang[sdcd_pkg::CmdW-1] ? (~tmp_ext + 1'b1) : tmp_ext;

  // Wheel sums 2*linear -/+ tmp, halved toward zero by halving the magnitude
  assign lin2  = {cmd_i.lin[sdcd_pkg::CmdW-1], cmd_i.lin, 1'b0};
  assign sum_l = lin2 - tmp_s;
  assign sum_r = lin2 + tmp_s;
  assign abs_l = sum_l[SumW-1] ? (~sum_l + 1'b1) : sum_l;
  assign abs_r = sum_r[SumW-1] ? (~sum_r + 1'b1) : sum_r;
  assign mag_l = abs_l[MagW:1];
  assign mag_r = abs_r[MagW:1];
  assign fwd_l = ~sum_l[SumW-1] | (mag_l == '0);
  assign fwd_r = ~sum_r[SumW-1] | (mag_r == '0);

  // Duty numerator and quotient by 10
  assign duty_num = prod[sdcd_pkg::OpW-1:0] - sdcd_pkg::DutyOffset;
  assign duty_quo = prod[sdcd_pkg::Shift10 +: sdcd_pkg::DutyW];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sdcd_pkg::MX_IDLE: if (start_i) state_d = sdcd_pkg::MX_ANG;
      sdcd_pkg::MX_ANG:  state_d = sdcd_pkg::MX_TMP;
      sdcd_pkg::MX_TMP:  state_d = sdcd_pkg::MX_MIX;
      sdcd_pkg::MX_MIX:  state_d = sdcd_pkg::MX_L125;
      sdcd_pkg::MX_L125: state_d = sdcd_pkg::MX_L10;
      sdcd_pkg::MX_L10:  state_d = sdcd_pkg::MX_R125;
      sdcd_pkg::MX_R125: state_d = sdcd_pkg::MX_R10;
      sdcd_pkg::MX_R10:  state_d = sdcd_pkg::MX_DONE;
      sdcd_pkg::MX_DONE: state_d = sdcd_pkg::MX_IDLE;
      default:           state_d = sdcd_pkg::MX_IDLE;
    endcase
  end

  // Operand select and register loads
  always_comb begin
    mul_en     = 1'b1;
    op_a       = '0;
    op_b       = '0;
    load_mix   = 1'b0;
    load_left  = 1'b0;
    load_right = 1'b0;
    busy_o     = 1'b1;
    done_o     = 1'b0;
    case (state_q)
      sdcd_pkg::MX_IDLE: begin
        mul_en = 1'b0;
        busy_o = 1'b0;
      end
      sdcd_pkg::MX_ANG: begin
        op_a = sdcd_pkg::OpW'(ang_abs);
        op_b = sdcd_pkg::OpW'(shaft_i);
      end
      sdcd_pkg::MX_TMP: begin
        op_a = prod[sdcd_pkg::OpW-1:0];
        op_b = sdcd_pkg::Recip100;
      end
      sdcd_pkg::MX_MIX: begin
        mul_en   = 1'b0;
        load_mix = 1'b1;
      end
      sdcd_pkg::MX_L125: begin
        op_a = sdcd_pkg::OpW'(lmag_q);
        op_b = sdcd_pkg::DutyGain;
      end
      sdcd_pkg::MX_L10: begin
        op_a = duty_num;
        op_b = sdcd_pkg::Recip10;
      end
      sdcd_pkg::MX_R125: begin
        load_left = 1'b1;
        op_a      = sdcd_pkg::OpW'(rmag_q);
        op_b      = sdcd_pkg::DutyGain;
      end
      sdcd_pkg::MX_R10: begin
        op_a = duty_num;
        op_b = sdcd_pkg::Recip10;
      end
      sdcd_pkg::MX_DONE: begin
        mul_en     = 1'b0;
        load_right = 1'b1;
        done_o     = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Hold sequencer state and wheel registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdcd_pkg::MX_IDLE;
      lfwd_q  <= 1'b1;
      rfwd_q  <= 1'b1;
      lduty_q <= '0;
      rduty_q <= '0;
    end else begin
      state_q <= state_d;
      if (load_mix) begin
        lfwd_q <= fwd_l;
        rfwd_q <= fwd_r;
      end
      if (load_left) begin
        lduty_q <= (lmag_q == '0) ? '0 : duty_quo;
      end
      if (load_right) begin
        rduty_q <= (rmag_q == '0) ? '0 : duty_quo;
      end
    end
  end

  // Wheel magnitudes are working values
  always_ff @(posedge clk_i) begin
    if (load_mix) begin
      lmag_q <= mag_l;
      rmag_q <= mag_r;
    end
  end

  assign left_duty_o  = lduty_q;
  assign right_duty_o = rduty_q;
  assign left_fwd_o   = lfwd_q;
  assign right_fwd_o  = rfwd_q;

endmodule

/* hw/rtl/serial_drive_command_decoder.sv */
// ----------------------------------------------------------------------------
// serial_drive_command_decoder
// Parses ':' 's' sign mag 'a' sign mag ... ESC commands from a serial byte
// stream and mixes them into left and right motor duty and direction values.
// Every accepted word gives one result word carrying an ack code and the
// current wheel registers. A word other than a mixing ESC gives its result
// on the next cycle. An ESC that ends a command starts the mixing sequence,
// which runs six products through one shared 16 by 16 multiplier, and the
// result word is registered when the sequence reaches its done state;
// rx_stall_o stays high meanwhile. The input is also stalled while a result
// waits and the output side stalls.
// ----------------------------------------------------------------------------
`include "serial_drive_command_decoder_defines.svh"

module serial_drive_command_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Shaft length register
  input  logic                          shaft_length_cm_we_i,
  input  logic [sdcd_pkg::ShaftW-1:0]   shaft_length_cm_i,
  // Byte input
  input  logic                          rx_valid_i,
  output logic                          rx_stall_o,
  input  logic [7:0]                    rx_byte_i,
  // Result output
  output logic                          tx_valid_o,
  input  logic                          tx_stall_i,
  output logic [1:0]                    ack_code_o,
  output logic [sdcd_pkg::DutyW-1:0]    left_duty_o,
  output logic [sdcd_pkg::DutyW-1:0]    right_duty_o,
  output logic                          left_forward_o,
  output logic                          right_forward_o
);

  logic [sdcd_pkg::ShaftW-1:0]  shaft_q;
  logic                         rx_acc;
  sdcd_pkg::cmd_t               cmd;
  sdcd_pkg::ack_e               parse_ack;
  logic                         mix_start;
  logic                         mix_busy;
  logic                         mix_done;
  logic                         tx_valid_q, tx_valid_d;
  sdcd_pkg::ack_e               ack_q, ack_d;

  // Stall while mixing or while a result word is held up
  assign rx_stall_o = mix_busy | (tx_valid_q & tx_stall_i);
  assign rx_acc     = rx_valid_i & ~rx_stall_o;

  // Shaft length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shaft_q <= sdcd_pkg::ShaftReset;
    end else if (shaft_length_cm_we_i) begin
      shaft_q <= shaft_length_cm_i;
    end
  end

  sdcd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (rx_acc),
    .rx_byte_i   (rx_byte_i),
    .cmd_o       (cmd),
    .ack_o       (parse_ack),
    .mix_start_o (mix_start)
  );

  sdcd_mix_seq u_mix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (mix_start),
    .cmd_i        (cmd),
    .shaft_i      (shaft_q),
    .busy_o       (mix_busy),
    .done_o       (mix_done),
    .left_duty_o  (left_duty_o),
    .right_duty_o (right_duty_o),
    .left_fwd_o   (left_forward_o),
    .right_fwd_o  (right_forward_o)
  );

  // Output word: drop on take, load on a parsed word or a finished mix
  always_comb begin
    tx_valid_d = tx_valid_q;
    ack_d      = ack_q;
    if (tx_valid_q && !tx_stall_i) begin
      tx_valid_d = 1'b0;
    end
    if (rx_acc && !mix_start) begin
      tx_valid_d = 1'b1;
      ack_d      = parse_ack;
    end
    if (mix_done) begin
      tx_valid_d = 1'b1;
      ack_d      = sdcd_pkg::ACK_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_valid_q <= 1'b0;
      ack_q      <= sdcd_pkg::ACK_NONE;
    end else begin
      tx_valid_q <= tx_valid_d;
      ack_q      <= ack_d;
    end
  end

  assign tx_valid_o = tx_valid_q;
  assign ack_code_o = ack_q;

  // No byte is taken while the mixing sequence runs
  `SDCD_ASSERT_IMPL(a_no_accept_in_mix, mix_busy, !rx_acc)
  // The output word is free when the mix finishes
  `SDCD_ASSERT_IMPL(a_out_free_at_done, mix_done, !tx_valid_q)
  // A finished mix presents a done word next
  `SDCD_ASSERT_NEXT(a_done_word, mix_done, tx_valid_o && (ack_code_o == sdcd_pkg::ACK_DONE))

endmodule

/* tb/tb_serial_drive_command_decoder.sv */
// ----------------------------------------------------------------------------
// tb_serial_drive_command_decoder
// Drives serial command bytes into the decoder and checks every result word
// against a cycle-free model of the parser and the wheel mixing. The run
// covers the reset state, directed commands at the field extremes, then
// random well-formed commands mixed with noise, under several shaft lengths
// and with random gaps on the byte side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_serial_drive_command_decoder;
  import sdcd_pkg::*;

  typedef struct packed {
    logic [1:0]       ack;
    logic [DutyW-1:0] left_duty;
    logic [DutyW-1:0] right_duty;
    logic             left_fwd;
    logic             right_fwd;
  } wheel_report_t;

  // DUT ports
  logic              clk_i                = 1'b0;
  logic              rst_ni               = 1'b0;
  logic              shaft_length_cm_we_i = 1'b0;
  logic [ShaftW-1:0] shaft_length_cm_i    = '0;
  logic              rx_valid_i           = 1'b0;
  logic              rx_stall_o;
  logic [7:0]        rx_byte_i            = '0;
  logic              tx_valid_o;
  logic              tx_stall_i           = 1'b0;
  logic [1:0]        ack_code_o;
  logic [DutyW-1:0]  left_duty_o;
  logic [DutyW-1:0]  right_duty_o;
  logic              left_forward_o;
  logic              right_forward_o;

  // Model state of the decoder
  phase_e            parse_ph;
  logic              neg_pend;
  logic signed [8:0] lin_cmd;
  logic signed [8:0] ang_cmd;
  logic [DutyW-1:0]  l_duty;
  logic [DutyW-1:0]  r_duty;
  logic              l_fwd;
  logic              r_fwd;
  logic [ShaftW-1:0] shaft_cm;

  wheel_report_t reports_q[$];
  bit            idle_on   = 1'b1;
  int            n_errors  = 0;
  int            n_sent    = 0;
  int            n_checked = 0;
  int            n_mixes   = 0;
  int            n_shafts  = 0;

  serial_drive_command_decoder u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .shaft_length_cm_we_i (shaft_length_cm_we_i),
    .shaft_length_cm_i    (shaft_length_cm_i),
    .rx_valid_i           (rx_valid_i),
    .rx_stall_o           (rx_stall_o),
    .rx_byte_i            (rx_byte_i),
    .tx_valid_o           (tx_valid_o),
    .tx_stall_i           (tx_stall_i),
    .ack_code_o           (ack_code_o),
    .left_duty_o          (left_duty_o),
    .right_duty_o         (right_duty_o),
    .left_forward_o       (left_forward_o),
    .right_forward_o      (right_forward_o)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Turn a signed wheel speed into direction and compare value
  function automatic void wheel_duty(input int speed, output logic [DutyW-1:0] duty,
                                     output logic fwd);
    int mag;
    fwd = (speed >= 0);
    mag = (speed < 0) ? -speed : speed;
    duty = (mag == 0) ? '0 : DutyW'((125 * mag - 7) / 10);
  endfunction

  // Differential-drive mixing; int division truncates toward zero
  function automatic void mix_wheels();
    int lin;
    int ang;
    int shaft;
    int tmp;
    lin   = lin_cmd;
    ang   = ang_cmd;
    shaft = shaft_cm;
    tmp   = (ang * shaft) / 100;
    wheel_duty((2 * lin - tmp) / 2, l_duty, l_fwd);
    wheel_duty((2 * lin + tmp) / 2, r_duty, r_fwd);
  endfunction

  // Advance the parser by one byte and return the result word it gives
  function automatic wheel_report_t decode_byte(input logic [7:0] b);
    wheel_report_t r;
    logic signed [8:0] val;
    r.ack = ACK_NONE;
    // one's complement of the magnitude for a minus sign
    val = neg_pend ? ~{1'b0, b} : {1'b0, b};
    case (parse_ph)
      PH_IDLE: begin
        if (b == CH_COLON) begin
          parse_ph = PH_RECV;
          r.ack    = ACK_RECV;
        end
      end
      PH_RECV: begin
        if (b == CH_S) begin
          parse_ph = PH_LIN_SIGN;
        end else if (b == CH_A) begin
          parse_ph = PH_ANG_SIGN;
        end else if (b == CH_ESC) begin
          mix_wheels();
          parse_ph = PH_IDLE;
          r.ack    = ACK_DONE;
        end
      end
      PH_LIN_SIGN: begin
        neg_pend = (b == CH_MINUS);
        parse_ph = PH_LIN_MAG;
      end
      PH_LIN_MAG: begin
        lin_cmd  = val;
        parse_ph = PH_RECV;
      end
      PH_ANG_SIGN: begin
        neg_pend = (b == CH_MINUS);
        parse_ph = PH_ANG_MAG;
      end
      PH_ANG_MAG: begin
        ang_cmd  = val;
        parse_ph = PH_RECV;
      end
      default: begin
        parse_ph = PH_IDLE;
      end
    endcase
    r.left_duty  = l_duty;
    r.right_duty = r_duty;
    r.left_fwd   = l_fwd;
    r.right_fwd  = r_fwd;
    return r;
  endfunction

  // Send one byte word, with an optional random gap ahead of it
  task automatic send_byte(input logic [7:0] b);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 17) begin
        rx_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    reports_q.push_back(decode_byte(b));
    @(posedge clk_i);
    while (rx_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  // Drop valid and hold until every expected word has come back
  task automatic wait_drained();
    rx_valid_i <= 1'b0;
    while (reports_q.size() != 0) @(posedge clk_i);
  endtask

  // Write the shaft length while the block is idle
  task automatic set_shaft(input logic [ShaftW-1:0] v);
    wait_drained();
    repeat (12) @(posedge clk_i);
    shaft_length_cm_we_i <= 1'b1;
    shaft_length_cm_i    <= v;
    @(posedge clk_i);
    shaft_length_cm_we_i <= 1'b0;
    shaft_cm = v;
    n_shafts++;
  endtask

  // Bytes outside a command leave the reset wheel state untouched
  task automatic test_idle_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_ESC);
  endtask

  // Empty command after reset: zero speed on both wheels
  task automatic test_zero_command();
    send_byte(CH_COLON);
    send_byte(CH_ESC);
  endtask

  // Largest forward linear and most negative angular command
  task automatic test_extreme_commands();
    send_byte(CH_COLON);
    send_byte(CH_S);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_A);
    send_byte(CH_MINUS);
    send_byte(8'hFF);
    send_byte(CH_ESC);
  endtask

  // Unknown bytes in receive mode, and control characters taken as raw fields
  task automatic test_raw_fields();
    send_byte(CH_COLON);
    send_byte(CH_S);
    send_byte(CH_MINUS);
    send_byte(8'hFF);
    send_byte(8'h78);
    send_byte(CH_COLON);
    send_byte(CH_A);
    send_byte(CH_ESC);
    send_byte(CH_ESC);
    send_byte(CH_ESC);
  endtask

  // Mostly well-formed commands with random content, some noise and cut-offs
  task automatic test_random_commands(input int n_words);
    int         start;
    logic [7:0] mag;
    start = n_sent;
    while (n_sent - start < n_words) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(CH_COLON);
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)));
          send_byte($urandom_range(0, 1) ? CH_S : CH_A);
          send_byte($urandom_range(0, 1) ? CH_MINUS : 8'($urandom_range(0, 255)));
          case ($urandom_range(0, 3))
            0:       mag = 8'h00;
            1:       mag = 8'hFF;
            default: mag = 8'($urandom_range(0, 255));
          endcase
          send_byte(mag);
        end
        if ($urandom_range(0, 15) != 0) send_byte(CH_ESC);
      end
    end
  endtask

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  // Check each accepted result word and drive random output stalls
  always @(posedge clk_i) begin
    wheel_report_t exp_r;
    if (rst_ni && tx_valid_o && !tx_stall_i) begin
      if (reports_q.size() == 0) begin
        $display("%0t: no result expected, got ack %0d duty %0d/%0d", $time,
                 ack_code_o, left_duty_o, right_duty_o);
        n_errors++;
      end else begin
        exp_r = reports_q.pop_front();
        check_field("ack_code", exp_r.ack, ack_code_o);
        check_field("left_duty", exp_r.left_duty, left_duty_o);
        check_field("right_duty", exp_r.right_duty, right_duty_o);
        check_field("left_forward", exp_r.left_fwd, left_forward_o);
        check_field("right_forward", exp_r.right_fwd, right_forward_o);
        n_checked++;
        if (exp_r.ack == ACK_DONE) n_mixes++;
      end
    end
    tx_stall_i <= idle_on && ($urandom_range(0, 99) < 17);
  end

  // Stimulus sequence
  initial begin
    parse_ph = PH_IDLE;
    neg_pend = 1'b0;
    lin_cmd  = '0;
    ang_cmd  = '0;
    l_duty   = '0;
    r_duty   = '0;
    l_fwd    = 1'b1;
    r_fwd    = 1'b1;
    shaft_cm = ShaftReset;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_noise();
    test_zero_command();
    test_extreme_commands();
    test_raw_fields();

    set_shaft(7'd100);
    test_random_commands(320);
    set_shaft(7'd0);
    test_random_commands(320);
    // long stretch without gaps or stalls
    set_shaft(7'd127);
    idle_on = 1'b0;
    test_random_commands(320);
    idle_on = 1'b1;
    set_shaft(7'($urandom_range(0, 127)));
    test_random_commands(320);
    set_shaft(7'd1);
    test_random_commands(320);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (reports_q.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time, reports_q.size());
      n_errors++;
    end

    $display("Sent %0d byte words, checked %0d result words, %0d of them wheel updates.",
             n_sent, n_checked, n_mixes);
    $display("Used the reset shaft length and %0d written ones.", n_shafts);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
